// ----- rtl/ebde_pkg.sv -----
// ============================================================================
// ebde_pkg: shared types and constants for the backfill decision engine
// Holds the request/result payload structs, command codes, the sequencer
// state type and the table entry type.
// ============================================================================
package ebde_pkg;

    localparam int MAX_RUNNING = 64;
    localparam int IDX_W       = $clog2(MAX_RUNNING);
    localparam int CNT_W       = $clog2(MAX_RUNNING + 1);

    localparam logic [1:0] CMD_FINISH = 2'd0;
    localparam logic [1:0] CMD_HEAD   = 2'd1;
    localparam logic [1:0] CMD_NEXT   = 2'd2;
    localparam logic [1:0] CMD_BAD    = 2'd3;   // unused code, no effect

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] job_tag;
        logic [6:0]  machines_wanted;
        logic [31:0] run_length;
        logic [31:0] now;
    } t_req;

    typedef struct packed {
        logic        started;
        logic [63:0] granted_mask;
        logic [31:0] head_shadow;
        logic [6:0]  head_spare;
        logic [6:0]  free_now;
        logic        hit;
        logic        table_full;
    } t_rsp;

    typedef struct packed {
        logic [15:0] tag;
        logic [6:0]  machines;
        logic [63:0] mask;
        logic [31:0] fin;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_GRANT,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_SHIFT_DN,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_ALLOC,
        ST_SHIFT_UP,
        ST_RESP
    } t_state;

endpackage

// ----- rtl/ebde_table_ram.sv -----
// ============================================================================
// ebde_table_ram: running job table storage
// One write port and one read port; read data registered.
// ============================================================================
module ebde_table_ram (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ebde_pkg::IDX_W-1:0] i_waddr,
    input  ebde_pkg::t_entry      i_wdata,
    input  logic [ebde_pkg::IDX_W-1:0] i_raddr,
    output ebde_pkg::t_entry      o_rdata
);
    import ebde_pkg::*;

    t_entry r_mem [MAX_RUNNING];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- rtl/easy_backfill_decision_engine_unit.sv -----
// ============================================================================
// easy_backfill_decision_engine_unit: EASY backfilling decision engine
// Sorted running-job table in a one-port-read RAM, walked by a sequencer.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------
//  request  | i_req_valid/o_req_rdy | i_req   (ebde_pkg::t_req)
//  result   | o_rsp_valid/i_rsp_rdy | o_rsp   (ebde_pkg::t_rsp)
//  config   | i_cfg_valid/o_cfg_rdy | i_cfg_data (machine_total)
//
// One request at a time: a decode state, the table work, a state to load the
// result. Finish: read and check each entry up to the tag, then move each later
// entry down. Start: pick machines (8 per cycle), read and check entries for the
// slot, read and move entries up, write. Shadow walk: read and check each entry.
// The single RAM read port with its registered output sets these steps.
// Reset is synchronous; the table needs no clearing (count is reset).
// A result waits in its output register; the next request is taken once
// the result has been accepted. A pending config write goes first.
// ============================================================================
module easy_backfill_decision_engine_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_rdy,
    input  ebde_pkg::t_req    i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_rdy,
    output ebde_pkg::t_rsp    o_rsp,
    input  logic              i_cfg_valid,
    output logic              o_cfg_rdy,
    input  logic [6:0]        i_cfg_data
);
    import ebde_pkg::*;

    t_state r_state, n_state;
    t_req   r_req;

    logic [CNT_W-1:0] r_count;
    logic [63:0]      r_free_mask;
    logic [6:0]       r_free_cnt;
    logic             r_head_vld;
    logic [15:0]      r_head_tag;
    logic [6:0]       r_head_req;
    logic [31:0]      r_shadow;
    logic [6:0]       r_spare;

    logic [CNT_W-1:0] r_ptr;      // walk pointer
    logic [CNT_W-1:0] r_pos;      // insert / remove position
    logic [7:0]       r_acc;
    logic [31:0]      r_end;
    logic [6:0]       r_want;
    logic [63:0]      r_grant;
    logic [6:0]       r_got;      // machines picked so far
    logic [2:0]       r_gbyte;    // byte of the free mask being scanned
    logic             r_started, r_hit, r_full;
    logic             r_rsp_vld;
    t_rsp             r_rsp;

    // RAM port signals
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    t_entry           ram_wdata, ram_rdata;

    ebde_table_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // saturating finish time
    logic [32:0] end_sum;
    logic [31:0] end_sat;
    assign end_sum = {1'b0, i_req.now} + {1'b0, i_req.run_length};
    assign end_sat = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];

    // lowest free machines, one byte of the free mask per cycle
    logic [7:0] chunk_mask;
    logic [6:0] chunk_got;
    always_comb begin
        chunk_got  = r_got;
        chunk_mask = '0;
        for (int b = 0; b < 8; b++) begin
            if (r_free_mask[{r_gbyte, 3'(b)}] && (chunk_got < r_want)) begin
                chunk_mask[b] = 1'b1;
                chunk_got     = chunk_got + 7'd1;
            end
        end
    end

    // effective head request and decision terms
    logic       new_head;
    logic [6:0] eff_req;
    logic [6:0] lim;
    logic       can_next;
    logic       tbl_full;
    assign new_head = !r_head_vld || (r_head_tag != r_req.job_tag);
    assign eff_req  = new_head ? r_req.machines_wanted : r_head_req;
    assign lim      = (r_free_cnt < r_spare) ? r_free_cnt : r_spare;
    assign can_next = ((r_req.machines_wanted <= r_free_cnt) && (r_end <= r_shadow))
                    || (r_req.machines_wanted < lim);
    assign tbl_full = (r_count >= CNT_W'(MAX_RUNNING));

    logic [7:0] acc_next;
    assign acc_next = r_acc + {1'b0, ram_rdata.machines};

    logic last_walk;
    assign last_walk = (r_ptr + CNT_W'(1) >= r_count);

    // handshakes
    assign o_req_rdy   = (r_state == ST_IDLE) && !r_rsp_vld && !i_cfg_valid;
    assign o_cfg_rdy   = (r_state == ST_IDLE) && !r_rsp_vld;
    assign o_rsp_valid = r_rsp_vld;
    assign o_rsp       = r_rsp;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid && o_req_rdy) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                priority if (r_req.cmd == CMD_FINISH) begin
                    n_state = (r_count == '0) ? ST_RESP : ST_FIND_RD;
                end else if (r_req.cmd == CMD_HEAD) begin
                    if (eff_req <= r_free_cnt) n_state = tbl_full ? ST_RESP : ST_GRANT;
                    else n_state = (r_count == '0) ? ST_RESP : ST_WALK_RD;
                end else if (r_req.cmd == CMD_NEXT) begin
                    n_state = (can_next && !tbl_full) ? ST_GRANT : ST_RESP;
                end else begin
                    n_state = ST_RESP;
                end
            end
            ST_GRANT:    n_state = (r_gbyte == 3'd7) ? ST_WALK_RD : ST_GRANT;
            ST_FIND_RD:  n_state = ST_FIND_CHK;
            ST_FIND_CHK: begin
                if (ram_rdata.tag == r_req.job_tag)
                    n_state = last_walk ? ST_RESP : ST_SHIFT_DN;
                else n_state = last_walk ? ST_RESP : ST_FIND_RD;
            end
            // r_count already holds the reduced count: last source index
            ST_SHIFT_DN: n_state = (r_ptr >= r_count) ? ST_RESP : ST_SHIFT_DN;
            ST_WALK_RD: begin
                if (r_started) n_state = (r_ptr >= r_count) ? ST_ALLOC : ST_WALK_CHK;
                else n_state = ST_WALK_CHK;
            end
            ST_WALK_CHK: begin
                if (r_started) begin
                    n_state = (ram_rdata.fin > r_end || last_walk) ? ST_ALLOC : ST_WALK_RD;
                end else begin
                    n_state = (acc_next >= {1'b0, r_head_req} || last_walk)
                              ? ST_RESP : ST_WALK_RD;
                end
            end
            ST_ALLOC:    n_state = (r_ptr > r_pos) ? ST_SHIFT_UP : ST_RESP;
            ST_SHIFT_UP: n_state = ST_ALLOC;
            ST_RESP:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // RAM controls
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_ptr[IDX_W-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = r_ptr[IDX_W-1:0];
        unique case (r_state)
            ST_FIND_CHK: begin
                // prefetch the entry after the match for the move down
                ram_raddr = IDX_W'(r_ptr + CNT_W'(1));
            end
            ST_SHIFT_DN: begin
                // data of entry r_ptr arrives; it moves to r_pos = r_ptr - 1
                ram_we    = 1'b1;
                ram_waddr = r_pos[IDX_W-1:0];
                ram_wdata = ram_rdata;
                ram_raddr = IDX_W'(r_ptr + CNT_W'(1));
            end
            ST_ALLOC: begin
                if (r_ptr > r_pos) begin
                    ram_raddr = IDX_W'(r_ptr - CNT_W'(1));
                end else begin
                    ram_we          = 1'b1;
                    ram_waddr       = r_pos[IDX_W-1:0];
                    ram_wdata.tag   = r_req.job_tag;
                    ram_wdata.machines = r_got;
                    ram_wdata.mask  = r_grant;
                    ram_wdata.fin   = r_end;
                end
            end
            ST_SHIFT_UP: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr[IDX_W-1:0];
                ram_wdata = ram_rdata;
            end
            default: ;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_free_mask <= '1;
            r_free_cnt  <= 7'd64;
            r_head_vld  <= 1'b0;
            r_head_tag  <= '0;
            r_head_req  <= '0;
            r_shadow    <= '0;
            r_spare     <= '0;
            r_rsp_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_rsp_vld && i_rsp_rdy) r_rsp_vld <= 1'b0;

            unique case (r_state)
                ST_IDLE: begin
                    if (i_cfg_valid && o_cfg_rdy) begin
                        logic [6:0] tot;
                        tot = (i_cfg_data > 7'd64) ? 7'd64 : i_cfg_data;
                        r_count     <= '0;
                        r_free_mask <= (tot == 7'd64) ? '1 : ((64'd1 << tot) - 64'd1);
                        r_free_cnt  <= tot;
                        r_head_vld  <= 1'b0;
                        r_head_tag  <= '0;
                        r_head_req  <= '0;
                        r_shadow    <= '0;
                        r_spare     <= '0;
                    end
                    if (i_req_valid && o_req_rdy) begin
                        r_req     <= i_req;
                        r_end     <= end_sat;
                        r_started <= 1'b0;
                        r_hit     <= 1'b0;
                        r_full    <= 1'b0;
                        r_grant   <= '0;
                        r_ptr     <= '0;
                    end
                end
                ST_DECODE: begin
                    r_ptr   <= '0;
                    r_acc   <= {1'b0, r_free_cnt};
                    r_got   <= '0;
                    r_gbyte <= '0;
                    priority if (r_req.cmd == CMD_HEAD) begin
                        if (new_head) begin
                            r_head_vld <= 1'b1;
                            r_head_tag <= r_req.job_tag;
                            r_head_req <= r_req.machines_wanted;
                        end
                        r_want <= eff_req;
                        if (eff_req <= r_free_cnt) begin
                            r_full    <= tbl_full;
                            r_started <= !tbl_full;
                        end
                    end else if (r_req.cmd == CMD_NEXT) begin
                        r_want <= r_req.machines_wanted;
                        if (can_next) begin
                            r_full    <= tbl_full;
                            r_started <= !tbl_full;
                        end
                    end else begin
                        r_want <= r_req.machines_wanted;
                    end
                end
                ST_GRANT: begin
                    r_grant[{r_gbyte, 3'd0} +: 8] <= chunk_mask;
                    r_got   <= chunk_got;
                    r_gbyte <= r_gbyte + 3'd1;
                end
                ST_FIND_RD: ;
                ST_FIND_CHK: begin
                    if (ram_rdata.tag == r_req.job_tag) begin
                        logic [7:0] fc;
                        fc = {1'b0, r_free_cnt} + {1'b0, ram_rdata.machines};
                        r_hit       <= 1'b1;
                        r_free_mask <= r_free_mask | ram_rdata.mask;
                        r_free_cnt  <= (fc > 8'd64) ? 7'd64 : fc[6:0];
                        r_count     <= r_count - CNT_W'(1);
                        r_pos       <= r_ptr;
                    end
                    r_ptr <= r_ptr + CNT_W'(1);
                end
                ST_SHIFT_DN: begin
                    r_pos <= r_pos + CNT_W'(1);
                    r_ptr <= r_ptr + CNT_W'(1);
                end
                ST_WALK_RD: begin
                    if (r_started) r_pos <= r_ptr;
                end
                ST_WALK_CHK: begin
                    if (r_started) begin
                        if (ram_rdata.fin > r_end) r_pos <= r_ptr;
                        else r_pos <= r_ptr + CNT_W'(1);
                        r_ptr <= (ram_rdata.fin > r_end || last_walk) ? r_count
                                 : r_ptr + CNT_W'(1);
                    end else begin
                        r_acc <= acc_next;
                        if (acc_next >= {1'b0, r_head_req}) begin
                            r_shadow <= ram_rdata.fin;
                            r_spare  <= 7'(acc_next - {1'b0, r_head_req});
                        end
                        r_ptr <= r_ptr + CNT_W'(1);
                    end
                end
                ST_ALLOC: begin
                    if (r_ptr <= r_pos) begin
                        r_free_mask <= r_free_mask & ~r_grant;
                        r_free_cnt  <= r_free_cnt - r_got;
                        r_count     <= r_count + CNT_W'(1);
                    end
                end
                ST_SHIFT_UP: r_ptr <= r_ptr - CNT_W'(1);
                ST_RESP: begin
                    r_rsp_vld          <= 1'b1;
                    r_rsp.started      <= r_started;
                    r_rsp.granted_mask <= r_grant;
                    r_rsp.head_shadow  <= r_shadow;
                    r_rsp.head_spare   <= r_spare;
                    r_rsp.free_now     <= r_free_cnt;
                    r_rsp.hit          <= r_hit;
                    r_rsp.table_full   <= r_full;
                end
                default: ;
            endcase
        end
    end

    // checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RUNNING)) else $error("table count overflow");
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= 7'd64) else $error("free count above 64");
    a_no_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_req_rdy) else $error("ready while busy");
    a_resp_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP) |=> o_rsp_valid) else $error("result not raised");

endmodule
